@@ design/kvls_pkg.sv @@
// Package for the key/value list with search.
// Holds the opcode, status and state codes and the control and search word types.
// No dependencies.
package kvls_pkg;

    localparam int KEY_W  = 32;
    localparam int VAL_W  = 64;
    localparam int HIDX_W = 5;
    localparam int OCNT_W = 6;

    typedef enum logic [1:0] {
        OP_APPEND  = 2'd0,
        OP_PREPEND = 2'd1,
        OP_POP     = 2'd2,
        OP_FIND    = 2'd3
    } kvls_op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_MISS  = 2'd3
    } kvls_status_t;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } kvls_state_t;

    // Write control broadcast to every cell
    typedef struct packed {
        logic                    prepend;
        logic                    append;
        logic signed [KEY_W-1:0] key;
        logic [VAL_W-1:0]        value;
    } kvls_ctrl_t;

    // Search word handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [HIDX_W-1:0] idx;
        logic [VAL_W-1:0]  value;
    } kvls_srch_t;

endpackage

@@ design/kvls_in_if.sv @@
// Input channel of the key/value list: valid/ready handshake with the operation word.
// Depends on kvls_pkg for field widths.
interface kvls_in_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         opcode;
    logic signed [kvls_pkg::KEY_W-1:0]  item_key;
    logic [kvls_pkg::VAL_W-1:0]         item_value;

    modport source (output valid, output opcode, output item_key, output item_value,
                    input ready);
    modport sink   (input valid, input opcode, input item_key, input item_value,
                    output ready);
endinterface

@@ design/kvls_out_if.sv @@
// Output channel of the key/value list: valid/ready handshake with the result word.
// Depends on kvls_pkg for field widths.
interface kvls_out_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic                         hit;
    logic [kvls_pkg::HIDX_W-1:0]  hit_index;
    logic [kvls_pkg::VAL_W-1:0]   hit_value;
    logic [kvls_pkg::OCNT_W-1:0]  entry_count;

    modport source (output valid, output status, output hit, output hit_index,
                    output hit_value, output entry_count, input ready);
    modport sink   (input valid, input status, input hit, input hit_index,
                    input hit_value, input entry_count, output ready);
endinterface

@@ design/kvls_cell.sv @@
// One list cell: holds one key/value entry, shifts on prepend, loads on append,
// and passes the search word to its upper neighbor. Depends on kvls_pkg.
module kvls_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  kvls_pkg::kvls_ctrl_t              ctrl,
    input  logic [CNT_W-1:0]                  count,
    input  logic signed [kvls_pkg::KEY_W-1:0] srch_key,
    input  logic signed [kvls_pkg::KEY_W-1:0] prev_key,
    input  logic [kvls_pkg::VAL_W-1:0]        prev_value,
    input  kvls_pkg::kvls_srch_t              srch_prev,
    output logic signed [kvls_pkg::KEY_W-1:0] held_key,
    output logic [kvls_pkg::VAL_W-1:0]        held_value,
    output kvls_pkg::kvls_srch_t              srch_here
);

    logic signed [kvls_pkg::KEY_W-1:0] key_reg;
    logic [kvls_pkg::VAL_W-1:0]        value_reg;
    kvls_pkg::kvls_srch_t              srch_reg;
    kvls_pkg::kvls_srch_t              srch_next;
    logic                              occupied;
    logic                              at_tail;

    assign occupied = count > CNT_W'(INDEX);
    assign at_tail  = count == CNT_W'(INDEX);

    // Shift up from the lower neighbor on prepend, load the item at the tail on append
    always_ff @(posedge clk)
    begin
        if (ctrl.prepend)
        begin
            key_reg   <= prev_key;
            value_reg <= prev_value;
        end
        else if (ctrl.append && at_tail)
        begin
            key_reg   <= ctrl.key;
            value_reg <= ctrl.value;
        end
    end

    // Claim the search word on the first match, otherwise pass it along
    always_comb
    begin
        srch_next = srch_prev;
        if (srch_prev.valid && !srch_prev.found && occupied && (key_reg == srch_key))
        begin
            srch_next.found = 1'b1;
            srch_next.idx   = kvls_pkg::HIDX_W'(INDEX);
            srch_next.value = value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srch_reg <= '0;
        end
        else
        begin
            srch_reg <= srch_next;
        end
    end

    assign held_key   = key_reg;
    assign held_value = value_reg;
    assign srch_here  = srch_reg;

endmodule

@@ design/key_value_list_with_search_core.sv @@
// Key/value list with search: a chain of CAPACITY cells. A word can be accepted every
// cycle while the block is idle with room at the output; an append, prepend or pop result
// is registered on the next edge. Find walks a search word up the cell chain one cell per
// cycle from the start register to the output register; no word is taken meanwhile.
// Reset clears the entry count, the search chain and the output valid; entries are not cleared.
// Depends on kvls_pkg, kvls_in_if, kvls_out_if and kvls_cell.
module key_value_list_with_search_core #(
    parameter int CAPACITY = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    kvls_in_if.sink    items,
    kvls_out_if.source results
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    kvls_pkg::kvls_state_t              state_reg;
    kvls_pkg::kvls_state_t              state_next;
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic                               start_reg;
    logic signed [kvls_pkg::KEY_W-1:0]  srch_key_reg;
    kvls_pkg::kvls_ctrl_t               ctrl;
    kvls_pkg::kvls_status_t             op_status;

    logic                               out_valid_reg;
    logic [1:0]                         out_status_reg;
    logic                               out_hit_reg;
    logic [kvls_pkg::HIDX_W-1:0]        out_idx_reg;
    logic [kvls_pkg::VAL_W-1:0]         out_value_reg;
    logic [kvls_pkg::OCNT_W-1:0]        out_count_reg;

    logic                               accept;
    logic                               is_find;
    logic                               full;
    logic                               slot_free;
    logic                               srch_done;

    logic signed [kvls_pkg::KEY_W-1:0]  cell_key   [CAPACITY];
    logic [kvls_pkg::VAL_W-1:0]         cell_value [CAPACITY];
    kvls_pkg::kvls_srch_t               srch_chain [CAPACITY+1];

    assign slot_free = !out_valid_reg || results.ready;
    assign accept    = items.valid && items.ready;
    assign is_find   = items.opcode == kvls_pkg::OP_FIND;
    assign full      = count_reg == CNT_W'(CAPACITY);
    assign srch_done = srch_chain[CAPACITY].valid;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kvls_pkg::S_IDLE:
            begin
                if (accept && is_find)
                begin
                    state_next = kvls_pkg::S_SEARCH;
                end
            end
            kvls_pkg::S_SEARCH:
            begin
                if (srch_done)
                begin
                    state_next = kvls_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kvls_pkg::S_IDLE;
            end
        endcase
    end

    // State outputs: take words only while idle with room at the output
    always_comb
    begin
        case (state_reg)
            kvls_pkg::S_IDLE:   items.ready = slot_free;
            kvls_pkg::S_SEARCH: items.ready = 1'b0;
            default:            items.ready = 1'b0;
        endcase
    end

    // Decode the list operation: cell control, status and new count
    always_comb
    begin
        ctrl.prepend = 1'b0;
        ctrl.append  = 1'b0;
        ctrl.key     = items.item_key;
        ctrl.value   = items.item_value;
        op_status    = kvls_pkg::ST_OK;
        count_next   = count_reg;
        case (items.opcode)
            kvls_pkg::OP_APPEND,
            kvls_pkg::OP_PREPEND:
            begin
                if (full)
                begin
                    op_status = kvls_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.append  = accept && (items.opcode == kvls_pkg::OP_APPEND);
                    ctrl.prepend = accept && (items.opcode == kvls_pkg::OP_PREPEND);
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            kvls_pkg::OP_POP:
            begin
                if (count_reg == '0)
                begin
                    op_status = kvls_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                op_status = kvls_pkg::ST_OK;
            end
        endcase
    end

    // Hold state, entry count and search start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kvls_pkg::S_IDLE;
            count_reg <= '0;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= accept && is_find;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_find)
        begin
            srch_key_reg <= items.item_key;
        end
    end

    // Inject the search word at the bottom of the chain
    assign srch_chain[0] = '{valid: start_reg, found: 1'b0, idx: '0, value: '0};

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [kvls_pkg::KEY_W-1:0] prev_key;
        logic [kvls_pkg::VAL_W-1:0]        prev_value;

        if (i == 0)
        begin : g_head
            assign prev_key   = items.item_key;
            assign prev_value = items.item_value;
        end
        else
        begin : g_body
            assign prev_key   = cell_key[i-1];
            assign prev_value = cell_value[i-1];
        end

        kvls_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .count      (count_reg),
            .srch_key   (srch_key_reg),
            .prev_key   (prev_key),
            .prev_value (prev_value),
            .srch_prev  (srch_chain[i]),
            .held_key   (cell_key[i]),
            .held_value (cell_value[i]),
            .srch_here  (srch_chain[i+1])
        );
    end

    // Output register: load on a non-find word or at the end of a search, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((accept && !is_find) || srch_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (srch_done)
        begin
            out_status_reg <= srch_chain[CAPACITY].found ? kvls_pkg::ST_OK : kvls_pkg::ST_MISS;
            out_hit_reg    <= srch_chain[CAPACITY].found;
            out_idx_reg    <= srch_chain[CAPACITY].idx;
            out_value_reg  <= srch_chain[CAPACITY].value;
            out_count_reg  <= kvls_pkg::OCNT_W'(count_reg);
        end
        else if (accept && !is_find)
        begin
            out_status_reg <= op_status;
            out_hit_reg    <= 1'b0;
            out_idx_reg    <= '0;
            out_value_reg  <= '0;
            out_count_reg  <= kvls_pkg::OCNT_W'(count_next);
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.status      = out_status_reg;
    assign results.hit         = out_hit_reg;
    assign results.hit_index   = out_idx_reg;
    assign results.hit_value   = out_value_reg;
    assign results.entry_count = out_count_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_find_enters_search: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_find |=> state_reg == kvls_pkg::S_SEARCH)
        else $error("find did not start a search");

    a_op_result_next: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_find |=> out_valid_reg)
        else $error("list operation gave no result");

    a_search_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        srch_done |-> !out_valid_reg)
        else $error("search finished while output still occupied");

    a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_hit_reg |-> out_status_reg == kvls_pkg::ST_OK)
        else $error("hit without ok status");

endmodule

@@ tb/tb_key_value_list_with_search_core.sv @@
// Self-checking testbench for key_value_list_with_search_core: directed and random list words,
// a list predictor updated on each accepted word and a field-by-field result scoreboard.
// Depends on kvls_pkg, kvls_in_if, kvls_out_if and the core RTL.
module tb_key_value_list_with_search_core;

    localparam int CAPACITY       = 32;
    localparam int RANDOM_WORDS   = 1500;
    localparam int STALL_LIMIT    = 1000;
    localparam int TAIL_CYCLES    = CAPACITY + 8;
    localparam int KEY_POOL_SIZE  = 10;
    localparam int RECENT_DEPTH   = 16;
    localparam int MAX_PRINTED    = 60;

    // One list operation waiting to be sent
    typedef struct {
        kvls_pkg::kvls_op_t                op;
        logic signed [kvls_pkg::KEY_W-1:0] key;
        logic [kvls_pkg::VAL_W-1:0]        value;
        bit                                hold;
    } list_word_t;

    // One predicted result word
    typedef struct packed {
        kvls_pkg::kvls_status_t      status;
        logic                        hit;
        logic [kvls_pkg::HIDX_W-1:0] idx;
        logic [kvls_pkg::VAL_W-1:0]  value;
        logic [kvls_pkg::OCNT_W-1:0] count;
    } list_result_t;

    typedef enum int {
        RUN_FILL,
        RUN_DRAIN,
        RUN_MIXED
    } run_kind_t;

    logic clk;
    logic rst_n = 1'b0;

    // Testbench-side drivers, known from time zero
    logic                              drv_valid = 1'b0;
    logic [1:0]                        drv_op    = kvls_pkg::OP_APPEND;
    logic signed [kvls_pkg::KEY_W-1:0] drv_key   = '0;
    logic [kvls_pkg::VAL_W-1:0]        drv_value = '0;
    logic                              rsp_ready = 1'b0;

    kvls_in_if  items_if ();
    kvls_out_if results_if ();

    assign items_if.valid      = drv_valid;
    assign items_if.opcode     = drv_op;
    assign items_if.item_key   = drv_key;
    assign items_if.item_value = drv_value;
    assign results_if.ready    = rsp_ready;

    key_value_list_with_search_core #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if)
    );

    // Predictor state: the list as the block should hold it
    logic signed [kvls_pkg::KEY_W-1:0] list_keys [CAPACITY];
    logic [kvls_pkg::VAL_W-1:0]        list_values [CAPACITY];
    int                                list_fill = 0;

    list_word_t   word_queue [$];
    list_result_t due_results [$];
    list_word_t   next_word;
    list_result_t got_result;
    list_result_t want_result;

    int n_in = 0;
    int n_out = 0;
    int total_words = 0;
    int error_count = 0;
    int stall_cycles = 0;
    int n_finds = 0;
    int n_hits = 0;
    int n_full = 0;
    int n_empty = 0;
    int peak_fill = 0;
    bit timed_out;

    assign timed_out = (stall_cycles >= STALL_LIMIT);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(string msg);
        if (error_count < MAX_PRINTED)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Apply one accepted word to the list and return the result it must give
    function automatic list_result_t kv_list_apply(kvls_pkg::kvls_op_t op,
                                                   logic signed [kvls_pkg::KEY_W-1:0] key,
                                                   logic [kvls_pkg::VAL_W-1:0] value);
        list_result_t r;
        int           i;
        r = '0;
        r.status = kvls_pkg::ST_OK;
        case (op)
            kvls_pkg::OP_APPEND, kvls_pkg::OP_PREPEND:
            begin
                if (list_fill >= CAPACITY)
                begin
                    r.status = kvls_pkg::ST_FULL;
                    n_full++;
                end
                else
                begin
                    if (op == kvls_pkg::OP_PREPEND)
                    begin
                        // shift every held entry up one place
                        for (i = list_fill; i > 0; i--)
                        begin
                            list_keys[i]   = list_keys[i-1];
                            list_values[i] = list_values[i-1];
                        end
                        list_keys[0]   = key;
                        list_values[0] = value;
                    end
                    else
                    begin
                        list_keys[list_fill]   = key;
                        list_values[list_fill] = value;
                    end
                    list_fill++;
                    if (list_fill > peak_fill)
                        peak_fill = list_fill;
                end
            end
            kvls_pkg::OP_POP:
            begin
                if (list_fill == 0)
                begin
                    r.status = kvls_pkg::ST_EMPTY;
                    n_empty++;
                end
                else
                    list_fill--;
            end
            default:
            begin
                // linear search, lowest index wins
                n_finds++;
                r.status = kvls_pkg::ST_MISS;
                for (i = 0; i < list_fill; i++)
                begin
                    if (list_keys[i] === key)
                    begin
                        r.status = kvls_pkg::ST_OK;
                        r.hit    = 1'b1;
                        r.idx    = i[kvls_pkg::HIDX_W-1:0];
                        r.value  = list_values[i];
                        n_hits++;
                        break;
                    end
                end
            end
        endcase
        r.count = list_fill[kvls_pkg::OCNT_W-1:0];
        return r;
    endfunction

    // Idle percentages per phase: sender-heavy, receiver-heavy, then none
    function automatic int send_idle_pct();
        if (n_in < total_words / 3)
            return 19;
        else if (n_in < 2 * total_words / 3)
            return 83;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (n_in < total_words / 3)
            return 83;
        else if (n_in < 2 * total_words / 3)
            return 19;
        return 0;
    endfunction

    // Driver: predict on accept, then present the next word or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
            drv_op    <= kvls_pkg::OP_APPEND;
            drv_key   <= '0;
            drv_value <= '0;
            n_in      <= 0;
        end
        else
        begin
            if (drv_valid && items_if.ready)
            begin
                due_results.push_back(kv_list_apply(kvls_pkg::kvls_op_t'(drv_op),
                                                    drv_key, drv_value));
                n_in <= n_in + 1;
            end
            if (!drv_valid || items_if.ready)
            begin
                // hold a marked word until every due result has drained
                if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct() &&
                    !(word_queue[0].hold && (n_in != n_out || (drv_valid && items_if.ready))))
                begin
                    next_word = word_queue.pop_front();
                    drv_op    <= next_word.op;
                    drv_key   <= next_word.key;
                    drv_value <= next_word.value;
                    drv_valid <= 1'b1;
                end
                else
                    drv_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            n_out     <= 0;
        end
        else
        begin
            if (results_if.valid && results_if.ready)
            begin
                n_out <= n_out + 1;
                got_result.status = kvls_pkg::kvls_status_t'(results_if.status);
                got_result.hit    = results_if.hit;
                got_result.idx    = results_if.hit_index;
                got_result.value  = results_if.hit_value;
                got_result.count  = results_if.entry_count;
                if (due_results.size() == 0)
                    report_mismatch("result word with nothing due");
                else
                begin
                    want_result = due_results.pop_front();
                    if (got_result.status !== want_result.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                        got_result.status, want_result.status));
                    if (got_result.hit !== want_result.hit)
                        report_mismatch($sformatf("hit got %b want %b",
                                        got_result.hit, want_result.hit));
                    if (got_result.idx !== want_result.idx)
                        report_mismatch($sformatf("hit_index got %0d want %0d",
                                        got_result.idx, want_result.idx));
                    if (got_result.value !== want_result.value)
                        report_mismatch($sformatf("hit_value got %h want %h",
                                        got_result.value, want_result.value));
                    if (got_result.count !== want_result.count)
                        report_mismatch($sformatf("entry_count got %0d want %0d",
                                        got_result.count, want_result.count));
                end
            end
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct());
        end
    end

    // Watchdog: count cycles with no word moving on either side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else if ((drv_valid && items_if.ready) || (results_if.valid && results_if.ready))
            stall_cycles <= 0;
        else if (stall_cycles < STALL_LIMIT)
            stall_cycles <= stall_cycles + 1;
    end

    // Stimulus, reset and end of run
    initial
    begin
        logic signed [kvls_pkg::KEY_W-1:0] key_pool [KEY_POOL_SIZE];
        logic signed [kvls_pkg::KEY_W-1:0] recent_keys [$];
        logic signed [kvls_pkg::KEY_W-1:0] k;
        logic [kvls_pkg::VAL_W-1:0]        v;
        kvls_pkg::kvls_op_t                op;
        run_kind_t                         run_kind;
        int                                gen_fill;
        int                                n_rand;
        int                                run_len;
        int                                r;
        int                                i;

        // extremes first, the rest random
        key_pool[0] = 32'sh7FFF_FFFF;
        key_pool[1] = 32'sh8000_0000;
        key_pool[2] = '0;
        key_pool[3] = -32'sd1;
        for (i = 4; i < KEY_POOL_SIZE; i++)
            key_pool[i] = $urandom;

        // directed: empty cases, key and value extremes, duplicates, deep find
        word_queue.push_back('{kvls_pkg::OP_POP,     '0,          '0,             1'b0});
        word_queue.push_back('{kvls_pkg::OP_FIND,    '0,          '0,             1'b0});
        word_queue.push_back('{kvls_pkg::OP_APPEND,  key_pool[0], {64{1'b1}},     1'b0});
        word_queue.push_back('{kvls_pkg::OP_PREPEND, key_pool[1], '0,             1'b0});
        word_queue.push_back('{kvls_pkg::OP_APPEND,  key_pool[2], {32{2'b01}},    1'b0});
        word_queue.push_back('{kvls_pkg::OP_PREPEND, key_pool[3], {32{2'b10}},    1'b0});
        word_queue.push_back('{kvls_pkg::OP_APPEND,  key_pool[0], 64'd1,          1'b0});
        word_queue.push_back('{kvls_pkg::OP_FIND,    key_pool[0], '0,             1'b0});
        word_queue.push_back('{kvls_pkg::OP_FIND,    key_pool[1], {64{1'b1}},     1'b0});
        word_queue.push_back('{kvls_pkg::OP_FIND,    key_pool[3], '0,             1'b0});
        word_queue.push_back('{kvls_pkg::OP_FIND,    key_pool[2], '0,             1'b0});
        word_queue.push_back('{kvls_pkg::OP_FIND,    32'sd12345,  '0,             1'b0});
        word_queue.push_back('{kvls_pkg::OP_POP,     '0,          '0,             1'b0});
        word_queue.push_back('{kvls_pkg::OP_FIND,    key_pool[0], '0,             1'b0});
        word_queue.push_back('{kvls_pkg::OP_POP,     '0,          '0,             1'b0});
        word_queue.push_back('{kvls_pkg::OP_POP,     '0,          '0,             1'b0});
        word_queue.push_back('{kvls_pkg::OP_POP,     '0,          '0,             1'b0});
        word_queue.push_back('{kvls_pkg::OP_POP,     '0,          '0,             1'b0});
        word_queue.push_back('{kvls_pkg::OP_POP,     key_pool[1], {64{1'b1}},     1'b0});
        word_queue.push_back('{kvls_pkg::OP_FIND,    key_pool[3], '0,             1'b0});
        gen_fill = 0;

        // random: fill, drain and mixed runs so the list swings empty to full
        n_rand = 0;
        while (n_rand < RANDOM_WORDS)
        begin
            run_kind = run_kind_t'($urandom_range(2));
            run_len  = $urandom_range(20, 70);
            repeat (run_len)
            begin
                r = $urandom_range(99);
                case (run_kind)
                    RUN_FILL:
                        op = (r < 42) ? kvls_pkg::OP_APPEND : (r < 84) ? kvls_pkg::OP_PREPEND :
                             (r < 94) ? kvls_pkg::OP_FIND : kvls_pkg::OP_POP;
                    RUN_DRAIN:
                        op = (r < 60) ? kvls_pkg::OP_POP : (r < 85) ? kvls_pkg::OP_FIND :
                             (r < 92) ? kvls_pkg::OP_APPEND : kvls_pkg::OP_PREPEND;
                    default:
                        op = kvls_pkg::kvls_op_t'(r % 4);
                endcase
                r = $urandom_range(99);
                if (op == kvls_pkg::OP_FIND)
                    k = (r < 40) ? key_pool[$urandom_range(KEY_POOL_SIZE-1)] :
                        (r < 75 && recent_keys.size() != 0) ?
                            recent_keys[$urandom_range(recent_keys.size()-1)] : $urandom;
                else
                    k = (r < 80) ? key_pool[$urandom_range(KEY_POOL_SIZE-1)] : $urandom;
                r = $urandom_range(9);
                v = (r == 0) ? '0 : (r == 1) ? {64{1'b1}} : {$urandom, $urandom};
                // track fill and recent keys for deep finds
                if ((op == kvls_pkg::OP_APPEND || op == kvls_pkg::OP_PREPEND) &&
                    gen_fill < CAPACITY)
                begin
                    gen_fill++;
                    recent_keys.push_back(k);
                    if (recent_keys.size() > RECENT_DEPTH)
                        void'(recent_keys.pop_front());
                end
                else if (op == kvls_pkg::OP_POP && gen_fill > 0)
                    gen_fill--;
                word_queue.push_back('{op, k, v,
                                       (n_rand == RANDOM_WORDS / 2) || (n_rand == 0)});
                n_rand++;
            end
        end
        total_words = word_queue.size();

        // release reset
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // wait for all words sent and all results back, then let the block settle
        while (!timed_out && !(word_queue.size() == 0 && !drv_valid && n_in == n_out))
            @(posedge clk);
        if (!timed_out)
            repeat (TAIL_CYCLES) @(posedge clk);

        if (timed_out)
            $display("TIMEOUT: no word moved for %0d cycles, %0d sent, %0d returned",
                     STALL_LIMIT, n_in, n_out);
        else if (due_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_results.size()));

        $display("Ran %0d list words: %0d finds with %0d hits, %0d full pushes rejected,",
                 n_in, n_finds, n_hits, n_full);
        $display("%0d empty pops, peak fill %0d of %0d, %0d mismatches",
                 n_empty, peak_fill, CAPACITY, error_count);
        if (!timed_out && error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
